@@ sv/centered_moving_average_defines.svh @@
// Assertion macros used by the centered moving average datapath
`ifndef CENTERED_MOVING_AVERAGE_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CMA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("centered moving average: check failed");

// Next-cycle implication, disabled during reset
`define CMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("centered moving average: check failed");

`endif

@@ sv/cma_pkg.sv @@
// Package: shared types and constants of the centered moving average filter
`timescale 1ns / 1ps

package cma_pkg;

   // Window size register
   localparam int unsigned CSR_W = 5;
   localparam logic [CSR_W-1:0] WINDOW_RESET = 5'd5;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_START,
      ST_READ,
      ST_DRAIN,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FIN
   } cma_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take_item;
      logic set_center;
      logic start_win;
      logic read_step;
      logic div_load;
      logic div_step;
      logic out_load;
      logic next_center;
      logic end_stream;
   } cma_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_item;
      logic emit;
      logic read_end;
      logic div_done;
      logic out_free;
      logic more;
   } cma_stat_type;

endpackage

@@ sv/cma_req_if.sv @@
// Interface: input sample channel with valid/ready handshake
`timescale 1ns / 1ps

interface cma_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

@@ sv/cma_rsp_if.sv @@
// Interface: smoothed result channel with valid/ready handshake
`timescale 1ns / 1ps

interface cma_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] average;
   logic                           last_result;

   modport source (output valid, output average, output last_result, input ready);
   modport sink   (input valid, input average, input last_result, output ready);
endinterface

@@ sv/cma_ctrl.sv @@
// Controller: state machine sequencing window reads, division and output
`timescale 1ns / 1ps

module cma_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cma_pkg::cma_stat_type stat,
   output cma_pkg::cma_cmd_type  cmd
);
   import cma_pkg::*;

   cma_state_type state_ff;
   cma_state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (stat.last_item || stat.emit) ? ST_START : ST_IDLE;
         end
         ST_START: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (stat.read_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (stat.out_free) state_in = stat.more ? ST_START : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take_item = req_valid;
         end
         ST_DECIDE: begin
            cmd.set_center = stat.last_item || stat.emit;
         end
         ST_START: begin
            cmd.start_win = 1'b1;
         end
         ST_READ: begin
            cmd.read_step = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_FIN: begin
            cmd.out_load    = stat.out_free;
            cmd.next_center = stat.out_free && stat.more;
            cmd.end_stream  = stat.out_free && !stat.more && stat.last_item;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/cma_dp.sv @@
// Datapath: sample ring, window accumulator, serial divider and output register
`timescale 1ns / 1ps
`include "centered_moving_average_defines.svh"

module cma_dp #(
   parameter int MAX_WINDOW   = 31,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [cma_pkg::CSR_W-1:0]      csr_wr_data,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_last_sample,
   input  cma_pkg::cma_cmd_type           cmd,
   output cma_pkg::cma_stat_type          stat,
   cma_rsp_if.source                      rsp
);
   import cma_pkg::*;

   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W   = CNT_W;
   localparam int DEPTH   = 2 ** PTR_W;
   localparam int SUM_W   = SAMPLE_WIDTH + CNT_W;
   localparam int BIT_W   = $clog2(SUM_W + 1);
   localparam int WIN_CAP = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
   localparam logic [6:0] CAP_V = 7'(WIN_CAP);

   // Sample ring
   logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic                           rd_vld_ff;
   logic [PTR_W-1:0]               rd_addr;

   // Stream state
   logic [CSR_W-1:0] window_ff;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [CNT_W-1:0] seen_ff;
   logic [CNT_W-1:0] half_ff;
   logic             last_item_ff;

   // Window walk
   logic [CNT_W-1:0] center_ff;
   logic [CNT_W-1:0] age_ff;
   logic [CNT_W-1:0] end_age;
   logic [CNT_W:0]   hi_age;
   logic [CNT_W-1:0] seen_m1;
   logic [SUM_W-1:0] sum_ff;

   // Divider
   logic [CNT_W-1:0] div_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [SUM_W-1:0] quo_ff;
   logic [BIT_W-1:0] bit_ff;
   logic             neg_ff;
   logic [CNT_W:0]   trial;
   logic             trial_ge;
   logic [SUM_W-1:0] result;

   // Output register
   logic                           out_vld_ff;
   logic signed [SAMPLE_WIDTH-1:0] avg_ff;
   logic                           last_res_ff;

   // Half window from the register: round up to odd, clamp to the cap
   logic [6:0]       win_odd;
   logic [6:0]       win_sel;
   logic [CNT_W-1:0] half_cur;
   logic [CNT_W-1:0] half_eff;

   assign win_odd  = {2'b00, window_ff} | 7'd1;
   assign win_sel  = (win_odd > CAP_V) ? CAP_V : win_odd;
   assign half_cur = CNT_W'(win_sel >> 1);
   assign half_eff = (seen_ff == '0) ? half_cur : half_ff;

   // Window bounds: ages 0 .. min(center + half, seen - 1)
   assign hi_age  = {1'b0, center_ff} + {1'b0, half_ff};
   assign seen_m1 = seen_ff - CNT_W'(1);
   assign end_age = (hi_age < {1'b0, seen_m1}) ? hi_age[CNT_W-1:0] : seen_m1;
   assign rd_addr = wr_ptr_ff - PTR_W'(1) - PTR_W'(age_ff);

   // Hold window size register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   // Write ring on each transaction, read one age per step
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         mem[wr_ptr_ff] <= req_sample;
      end
      if (cmd.read_step) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Track stream position
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         seen_ff      <= '0;
         half_ff      <= '0;
         last_item_ff <= 1'b0;
      end else if (cmd.take_item) begin
         wr_ptr_ff    <= wr_ptr_ff + PTR_W'(1);
         half_ff      <= half_eff;
         last_item_ff <= req_last_sample;
         if ({1'b0, seen_ff} < {half_eff, 1'b1}) begin
            seen_ff <= seen_ff + CNT_W'(1);
         end
      end else if (cmd.end_stream) begin
         wr_ptr_ff <= '0;
         seen_ff   <= '0;
      end
   end

   // Select window center
   always_ff @(posedge clock) begin
      if (cmd.set_center) begin
         if (last_item_ff && (seen_m1 < half_ff)) begin
            center_ff <= seen_m1;
         end else begin
            center_ff <= half_ff;
         end
      end else if (cmd.next_center) begin
         center_ff <= center_ff - CNT_W'(1);
      end
   end

   // Walk ages and accumulate read data in the cycle after each read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.read_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_win) begin
         age_ff <= '0;
         sum_ff <= '0;
      end else begin
         if (cmd.read_step) begin
            age_ff <= age_ff + CNT_W'(1);
         end
         if (rd_vld_ff) begin
            sum_ff <= sum_ff + {{CNT_W{rd_data_ff[SAMPLE_WIDTH-1]}}, rd_data_ff};
         end
      end
   end

   // Restoring division of the magnitude, one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_ff <= end_age + CNT_W'(1);
         neg_ff <= sum_ff[SUM_W-1];
         quo_ff <= sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
         rem_ff <= '0;
         bit_ff <= BIT_W'(SUM_W);
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], trial_ge};
         bit_ff <= bit_ff - BIT_W'(1);
      end
   end

   // Restore sign: truncation toward zero
   assign result = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;

   // Hold result until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         avg_ff      <= result[SAMPLE_WIDTH-1:0];
         last_res_ff <= last_item_ff && (center_ff == '0);
      end
   end

   assign rsp.valid       = out_vld_ff;
   assign rsp.average     = avg_ff;
   assign rsp.last_result = last_res_ff;

   // Report status
   assign stat.last_item = last_item_ff;
   assign stat.emit      = seen_ff > half_ff;
   assign stat.read_end  = age_ff == end_age;
   assign stat.div_done  = bit_ff == BIT_W'(1);
   assign stat.out_free  = !out_vld_ff || rsp.ready;
   assign stat.more      = last_item_ff && (center_ff != '0);

   // Checks
   `CMA_ASSERT_IMPL(a_div_nonzero, clock, reset, cmd.div_step, div_ff != '0)
   `CMA_ASSERT_IMPL(a_read_in_stream, clock, reset, cmd.read_step, age_ff < seen_ff)
   `CMA_ASSERT_IMPL(a_out_no_overwrite, clock, reset, cmd.out_load, !out_vld_ff || rsp.ready)
   `CMA_ASSERT_NEXT(a_seen_bound, clock, reset, cmd.take_item, seen_ff <= (half_ff << 1) + 1'b1)

endmodule

@@ sv/centered_moving_average.sv @@
// Per result: ring reads of each sample in the window, a drain state, the serial divider over
// SAMPLE_WIDTH + clog2(MAX_WINDOW+1) quotient bits, and the control states around them.
// Each accepted sample causes no result, one, or up to half window + 1 on the last sample. A new
// sample is taken only once all its results are loaded; a load waits while the sink holds a result.
// Reset: synchronous, active high; clears control, pointers and window size (to 5). The sample
// ring is not cleared and needs no clearing pass; only entries of the current stream are read.
`timescale 1ns / 1ps

module centered_moving_average #(
   parameter int MAX_WINDOW   = 31,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   cma_req_if.sink                   req,
   cma_rsp_if.source                 rsp,
   input  logic                      csr_wr_en,
   input  logic [cma_pkg::CSR_W-1:0] csr_wr_data
);
   import cma_pkg::*;

   cma_cmd_type  cmd;
   cma_stat_type stat;
   logic         ready_w;

   assign req.ready = ready_w;

   // Sequence each transaction
   cma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready_w),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store samples and compute window means
   cma_dp #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_sample      (req.sample),
      .req_last_sample (req.last_sample),
      .cmd             (cmd),
      .stat            (stat),
      .rsp             (rsp)
   );

endmodule
